// ----- hw/rtl/pf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair stream package
// Shared constants, the result beat type and small helpers for letter folding
// and 5x5 square coordinate arithmetic.
// ----------------------------------------------------------------------------
package pf_pkg;

  // Square geometry and letter coding.
  localparam int LetterW = 5;
  localparam int PosW    = 5;
  localparam int Cells   = 25;
  localparam int Letters = 26;

  localparam logic [LetterW-1:0] LetterI    = 5'd8;
  localparam logic [LetterW-1:0] LetterJ    = 5'd9;
  localparam logic [LetterW-1:0] LetterX    = 5'd23;
  localparam logic [LetterW-1:0] LetterZ    = 5'd25;
  localparam logic [LetterW-1:0] LetterLast = 5'd25;
  localparam logic [LetterW-1:0] LetterNone = 5'd26;
  localparam logic [LetterW-1:0] CellsFull  = 5'd25;
  localparam logic [PosW-1:0]    CellLast   = 5'd24;

  // Input commands.
  localparam logic [1:0] CmdKey     = 2'd0;
  localparam logic [1:0] CmdKeyDone = 2'd1;
  localparam logic [1:0] CmdText    = 2'd2;
  localparam logic [1:0] CmdEnd     = 2'd3;

  // Configuration port.
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam logic [ApbAddrW-3:0] RegMode = '0;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [PosW-1:0]    pos_t;
  typedef logic [2:0]         coord_t;

  // One result beat.
  typedef struct packed {
    logic [6:0] letter;
    logic       valid;
    logic       last;
    logic       odd;
  } beat_t;

  // Folds an ASCII byte to a letter code 0..25, or LetterNone.
  function automatic letter_t fold(input logic [7:0] ch);
    letter_t res;
    res = LetterNone;
    if (ch inside {[8'h41:8'h5A]}) begin
      res = letter_t'(ch - 8'h41);
    end else if (ch inside {[8'h61:8'h7A]}) begin
      res = letter_t'(ch - 8'h61);
    end
    return res;
  endfunction

  // Row of a cell index.
  function automatic coord_t row_of(input pos_t p);
    coord_t r;
    if (p >= 5'd20) begin
      r = 3'd4;
    end else if (p >= 5'd15) begin
      r = 3'd3;
    end else if (p >= 5'd10) begin
      r = 3'd2;
    end else if (p >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  // Cell index from row and column.
  function automatic pos_t pos_of(input coord_t r, input coord_t c);
    return pos_t'({r, 2'b00}) + pos_t'(r) + pos_t'(c);
  endfunction

  // Column of a cell index.
  function automatic coord_t col_of(input pos_t p);
    pos_t t;
    t = p - pos_of(row_of(p), 3'd0);
    return coord_t'(t);
  endfunction

  // Moves a coordinate one step right/down, or left/up for decrypt, wrapping.
  function automatic coord_t wrap_step(input coord_t x, input logic dec);
    coord_t r;
    if (dec) begin
      r = (x == 3'd0) ? 3'd4 : x - 3'd1;
    end else begin
      r = (x == 3'd4) ? 3'd0 : x + 3'd1;
    end
    return r;
  endfunction

  // Lowercase ASCII for a letter code.
  function automatic logic [6:0] to_ascii(input letter_t l);
    return 7'd97 + {2'b00, l};
  endfunction

  // Filler letter placed after the given one.
  function automatic letter_t filler_of(input letter_t l);
    return (l == LetterX) ? LetterZ : LetterX;
  endfunction

endpackage

// ----- hw/rtl/pf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Read data registered; a read of the entry being written returns the old
  // contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/pf_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair configuration registers
// APB-style register port holding the mode bit.
// ----------------------------------------------------------------------------
module pf_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pf_pkg::ApbAddrW-1:0]  paddr,
  input  logic [pf_pkg::ApbDataW-1:0]  pwdata,
  output logic [pf_pkg::ApbDataW-1:0]  prdata,
  output logic                         pready,
  output logic                         mode
);
  import pf_pkg::*;

  logic hit;
  logic wr;

  // Word decode; low byte-lane bits are ignored.
  assign hit    = (paddr[ApbAddrW-1:2] == RegMode);
  assign wr     = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = hit ? {{(ApbDataW-1){1'b0}}, mode} : '0;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (wr && hit) begin
      mode <= pwdata[0];
    end
  end

endmodule

// ----- hw/rtl/pf_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair result queue
// Two-entry queue that holds result beats until the receiver takes them.
// ----------------------------------------------------------------------------
module pf_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_n,
  input  pf_pkg::beat_t   push0,
  input  pf_pkg::beat_t   push1,
  output logic [1:0]      free,
  output logic            out_valid,
  input  logic            out_ready,
  output pf_pkg::beat_t   head
);
  import pf_pkg::*;

  beat_t      q0;
  beat_t      q1;
  logic [1:0] cnt;
  beat_t      q0_next;
  beat_t      q1_next;
  logic [1:0] cnt_next;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign head      = q0;
  assign free      = 2'd2 - cnt;
  assign pop       = out_valid & out_ready;

  // Pop shifts the queue, then pushes append behind what is left.
  always_comb begin
    q0_next  = q0;
    q1_next  = q1;
    cnt_next = cnt;
    if (pop) begin
      q0_next  = q1;
      cnt_next = cnt_next - 2'd1;
    end
    if (push_n != 2'd0) begin
      if (cnt_next == 2'd0) begin
        q0_next = push0;
      end else begin
        q1_next = push0;
      end
      cnt_next = cnt_next + 2'd1;
    end
    if (push_n == 2'd2) begin
      q1_next  = push1;
      cnt_next = cnt_next + 2'd1;
    end
  end

  // Payload needs no reset; the count does.
  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

// ----- hw/rtl/playfair_cipher_stream.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair cipher stream
// Builds a 5x5 key square in RAM and encrypts or decrypts a letter stream.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the in_valid/in_ready channel (cmd, in_char): key byte,
// key complete, text byte, end of message. Results leave on out_valid/
// out_ready as beats of out_letter, letter_valid, last and odd_error.
// The mode bit (0 encrypt, 1 decrypt) sits at APB address 0; the user must
// write it only while the block is idle, which the block does not enforce.
// A key byte or a dropped byte is taken while idle. Key complete walks the
// alphabet into the square RAM, reads the square back to write the letter
// map, then marks the key ready. A text byte that closes a pair passes two
// map reads and two square reads through the single read ports of the two
// RAMs, then the hand-off to the result queue. End of message emits either a
// padded final pair or a single marker beat.
// Reset clears the key, the pending letter and the queue; the square and the
// map hold nothing useful until the next key complete.
// A two-beat result queue decouples the receiver: the block keeps taking
// items while beats wait, and beyond an item's own cycles holds in_ready low
// only when a finished item finds too little room in the queue.
// ----------------------------------------------------------------------------
module playfair_cipher_stream (
  input  logic                         clk,
  input  logic                         rst,
  // Command channel.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   cmd,
  input  logic [7:0]                   in_char,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [6:0]                   out_letter,
  output logic                         letter_valid,
  output logic                         last,
  output logic                         odd_error,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pf_pkg::ApbAddrW-1:0]  paddr,
  input  logic [pf_pkg::ApbDataW-1:0]  pwdata,
  output logic [pf_pkg::ApbDataW-1:0]  prdata,
  output logic                         pready
);
  import pf_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FILL   = 4'd1;
  localparam logic [3:0] S_MAP    = 4'd2;
  localparam logic [3:0] S_MAPEND = 4'd3;
  localparam logic [3:0] S_LPA    = 4'd4;
  localparam logic [3:0] S_LPB    = 4'd5;
  localparam logic [3:0] S_SQA    = 4'd6;
  localparam logic [3:0] S_SQB    = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0]   state;
  logic         mode;
  logic [25:0]  used;
  letter_t      key_len;
  logic         key_ready;
  letter_t      pend_letter;
  logic         pend_valid;
  letter_t      cnt;
  logic         map_wr;
  pos_t         map_cell;
  letter_t      let_a;
  letter_t      let_b;
  logic         dec;
  logic         last_flag;
  pos_t         pa;
  pos_t         ob_pos;
  letter_t      la;
  beat_t        res0;
  beat_t        res1;
  logic [1:0]   res_n;

  // RAM ports.
  logic         sq_we;
  pos_t         sq_waddr;
  letter_t      sq_wdata;
  pos_t         sq_raddr;
  letter_t      sq_rdata;
  letter_t      lp_raddr;
  pos_t         lp_rdata;

  // Queue ports.
  logic [1:0]   push_n;
  logic [1:0]   free;
  beat_t        head;

  // Decode of the incoming byte and the key bookkeeping.
  logic         accept;
  letter_t      c;
  letter_t      tc;
  logic [25:0]  used_base;
  letter_t      len_base;
  logic         key_add;
  logic         fill_add;
  coord_t       ra, ca, rb, cb;
  pos_t         oa_pos;
  pos_t         ob_pos_calc;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign c        = fold(in_char);
  assign tc       = (c == LetterJ) ? LetterI : c;

  assign used_base = key_ready ? '0 : used;
  assign len_base  = key_ready ? '0 : key_len;
  assign key_add   = (c != LetterNone) && (c != LetterJ) && !used_base[c] &&
                     (len_base < CellsFull);
  assign fill_add  = (cnt != LetterJ) && !used[cnt] && (key_len < CellsFull);

  // Pair transform: row, column or rectangle rule.
  always_comb begin
    ra = row_of(pa);
    ca = col_of(pa);
    rb = row_of(lp_rdata);
    cb = col_of(lp_rdata);
    if (ra == rb) begin
      oa_pos      = pos_of(ra, wrap_step(ca, dec));
      ob_pos_calc = pos_of(rb, wrap_step(cb, dec));
    end else if (ca == cb) begin
      oa_pos      = pos_of(wrap_step(ra, dec), ca);
      ob_pos_calc = pos_of(wrap_step(rb, dec), cb);
    end else begin
      oa_pos      = pos_of(ra, cb);
      ob_pos_calc = pos_of(rb, ca);
    end
  end

  // Square RAM port selection.
  always_comb begin
    sq_we    = 1'b0;
    sq_waddr = len_base;
    sq_wdata = c;
    sq_raddr = '0;
    case (state)
      S_IDLE: begin
        sq_we = accept && (cmd == CmdKey) && key_add;
      end
      S_FILL: begin
        sq_we    = fill_add;
        sq_waddr = key_len;
        sq_wdata = cnt;
      end
      S_MAP: begin
        sq_raddr = cnt;
      end
      S_SQA: begin
        sq_raddr = oa_pos;
      end
      S_SQB: begin
        sq_raddr = ob_pos;
      end
      default: begin
        sq_we = 1'b0;
      end
    endcase
  end

  // Letter map read address.
  assign lp_raddr = (state == S_LPB) ? let_b : let_a;

  // Queue push.
  assign push_n = ((state == S_EMIT) && (free >= res_n)) ? res_n : 2'd0;

  // Control sequencer.
  always_ff @(posedge clk) begin
    map_wr   <= (state == S_MAP);
    map_cell <= cnt;
    if (rst) begin
      state       <= S_IDLE;
      used        <= '0;
      key_len     <= '0;
      key_ready   <= 1'b0;
      pend_letter <= '0;
      pend_valid  <= 1'b0;
      cnt         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              CmdKey: begin
                key_ready <= 1'b0;
                used      <= used_base | (key_add ? (26'd1 << c) : 26'd0);
                key_len   <= len_base + (key_add ? 5'd1 : 5'd0);
              end
              CmdKeyDone: begin
                pend_valid  <= 1'b0;
                pend_letter <= '0;
                cnt         <= '0;
                state       <= S_FILL;
              end
              CmdText: begin
                if (key_ready && (c != LetterNone)) begin
                  if (!pend_valid) begin
                    pend_letter <= tc;
                    pend_valid  <= 1'b1;
                  end else begin
                    dec       <= mode;
                    last_flag <= 1'b0;
                    let_a     <= pend_letter;
                    state     <= S_LPA;
                    if (!mode && (tc == pend_letter)) begin
                      let_b <= filler_of(pend_letter);
                    end else begin
                      let_b       <= tc;
                      pend_valid  <= 1'b0;
                      pend_letter <= '0;
                    end
                  end
                end
              end
              default: begin
                // End of message.
                pend_valid  <= 1'b0;
                pend_letter <= '0;
                if (pend_valid && key_ready && !mode) begin
                  dec       <= 1'b0;
                  last_flag <= 1'b1;
                  let_a     <= pend_letter;
                  let_b     <= filler_of(pend_letter);
                  state     <= S_LPA;
                end else begin
                  res0  <= '{letter: 7'd0, valid: 1'b0, last: 1'b1,
                             odd: pend_valid & mode};
                  res_n <= 2'd1;
                  state <= S_EMIT;
                end
              end
            endcase
          end
        end
        S_FILL: begin
          if (fill_add) begin
            used    <= used | (26'd1 << cnt);
            key_len <= key_len + 5'd1;
          end
          if (cnt == LetterLast) begin
            cnt   <= '0;
            state <= S_MAP;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_MAP: begin
          if (cnt == CellLast) begin
            state <= S_MAPEND;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_MAPEND: begin
          key_ready <= 1'b1;
          state     <= S_IDLE;
        end
        S_LPA: begin
          state <= S_LPB;
        end
        S_LPB: begin
          pa    <= lp_rdata;
          state <= S_SQA;
        end
        S_SQA: begin
          ob_pos <= ob_pos_calc;
          state  <= S_SQB;
        end
        S_SQB: begin
          la    <= sq_rdata;
          state <= S_FIN;
        end
        S_FIN: begin
          res0  <= '{letter: to_ascii(la), valid: 1'b1, last: 1'b0, odd: 1'b0};
          res1  <= '{letter: to_ascii(sq_rdata), valid: 1'b1, last: last_flag,
                     odd: 1'b0};
          res_n <= 2'd2;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (free >= res_n) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Key square: cell index to letter.
  pf_ram #(
    .Width (LetterW),
    .Depth (Cells)
  ) u_square (
    .clk   (clk),
    .we    (sq_we),
    .waddr (sq_waddr),
    .wdata (sq_wdata),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  // Letter map: letter to cell index, written from square read-back.
  pf_ram #(
    .Width (PosW),
    .Depth (Letters)
  ) u_letter_pos (
    .clk   (clk),
    .we    (map_wr),
    .waddr (sq_rdata),
    .wdata (map_cell),
    .raddr (lp_raddr),
    .rdata (lp_rdata)
  );

  // Configuration registers.
  pf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode)
  );

  // Result queue.
  pf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_letter   = head.letter;
  assign letter_valid = head.valid;
  assign last         = head.last;
  assign odd_error    = head.odd;

endmodule
